// ----- rtl/spcg_pkg.sv -----
// Shared types and widths for the sphere pair contact geometry unit.
package spcg_pkg;

	localparam int DIFF_W = 33;            // center difference, signed Q17.16
	localparam int MAG_W  = 33;            // magnitude of a center difference
	localparam int SUM_W  = 66;            // sum of squared differences, Q34.32
	localparam int DIST_W = 33;            // center distance, Q17.16
	localparam int ARM_W  = 35;            // lever arm r1 - depth/2, signed Q18.17
	localparam int NUM_W  = 63;            // dividend of the normal division
	localparam int QUO_W  = 31;            // normal magnitude, Q1.30

	localparam logic [QUO_W-1:0] ONE_Q30 = 31'h4000_0000;

	// One classified pair as it travels from the front part to the back part.
	typedef struct packed {
		logic                      touching;
		logic [31:0]               depth;
		logic [2:0][31:0]          p1;
		logic [2:0]                neg;
		logic [2:0][MAG_W-1:0]     mag;
		logic [DIST_W-1:0]         center_dist;
		logic [ARM_W-1:0]          arm;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ----- rtl/spcg_front.sv -----
// Front part: center differences, squared distance, pipelined root, depth test.
module spcg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [255:0]    s_tdata,
	input  logic            queue_full,
	output logic            item_valid,
	output spcg_pkg::item_t item
);
	import spcg_pkg::*;

	typedef struct packed {
		logic [2:0][31:0]      p1;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
		logic [30:0]           r1;
		logic [30:0]           r2;
	} geo_t;

	logic                   en;
	logic                   v_s1, v_s2, v_s3;
	logic [2:0][31:0]       p1_s1;
	logic [2:0][DIFF_W-1:0] d_s1;
	logic [30:0]            r1_s1, r2_s1;
	geo_t                   geo_s2, geo_s3;
	logic [2:0][SUM_W-1:0]  sq_s3;

	logic                   rt_v_s    [DIST_W+1];
	logic [SUM_W-1:0]       rt_rem_s  [DIST_W+1];
	logic [DIST_W-1:0]      rt_root_s [DIST_W+1];
	geo_t                   rt_geo_s  [DIST_W+1];

	logic [SUM_W-1:0]       trial     [DIST_W];
	logic [SUM_W-1:0]       rem_nx    [DIST_W];
	logic [DIST_W-1:0]      root_nx   [DIST_W];

	logic                   out_v_s;
	item_t                  out_s;
	logic [ARM_W-1:0]       depth_w, arm_w;
	logic [DIST_W-1:0]      dist_w;
	geo_t                   geo_w;

	assign en         = !(out_v_s && queue_full);
	assign s_tready   = en;
	assign item_valid = out_v_s;
	assign item       = out_s;

	// One result bit of the root per stage, restoring form on the remainder.
	always_comb begin
		for (int k = 0; k < DIST_W; k++) begin
			trial[k] = (SUM_W'(rt_root_s[k]) << (DIST_W - k)) |
				(SUM_W'(1) << (2 * (DIST_W - 1 - k)));
			if (trial[k] <= rt_rem_s[k]) begin
				rem_nx[k]  = rt_rem_s[k] - trial[k];
				root_nx[k] = rt_root_s[k] | (DIST_W'(1) << (DIST_W - 1 - k));
			end else begin
				rem_nx[k]  = rt_rem_s[k];
				root_nx[k] = rt_root_s[k];
			end
		end
	end

	always_comb begin
		dist_w  = rt_root_s[DIST_W];
		geo_w   = rt_geo_s[DIST_W];
		depth_w = ARM_W'(geo_w.r1) + ARM_W'(geo_w.r2) - ARM_W'(dist_w);
		arm_w   = ARM_W'(geo_w.r1) - ARM_W'(geo_w.r2) + ARM_W'(dist_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_s <= 1'b0;
			for (int k = 0; k <= DIST_W; k++) rt_v_s[k] <= 1'b0;
		end else if (en) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			rt_v_s[0] <= v_s3;
			for (int k = 0; k < DIST_W; k++) rt_v_s[k+1] <= rt_v_s[k];
			out_v_s   <= rt_v_s[DIST_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p1_s1[i] <= s_tdata[32*i +: 32];
				d_s1[i]  <= DIFF_W'($signed(s_tdata[96+32*i +: 32])) -
					DIFF_W'($signed(s_tdata[32*i +: 32]));
			end
			r1_s1 <= s_tdata[222:192];
			r2_s1 <= s_tdata[253:223];

			geo_s2.p1 <= p1_s1;
			geo_s2.r1 <= r1_s1;
			geo_s2.r2 <= r2_s1;
			for (int i = 0; i < 3; i++) begin
				geo_s2.neg[i] <= d_s1[i][DIFF_W-1];
				geo_s2.mag[i] <= d_s1[i][DIFF_W-1] ? (DIFF_W'(0) - d_s1[i]) : d_s1[i];
			end

			geo_s3 <= geo_s2;
			for (int i = 0; i < 3; i++)
				sq_s3[i] <= SUM_W'(geo_s2.mag[i]) * SUM_W'(geo_s2.mag[i]);

			rt_geo_s[0]  <= geo_s3;
			rt_rem_s[0]  <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			rt_root_s[0] <= '0;
			for (int k = 0; k < DIST_W; k++) begin
				rt_geo_s[k+1]  <= rt_geo_s[k];
				rt_rem_s[k+1]  <= rem_nx[k];
				rt_root_s[k+1] <= root_nx[k];
			end

			out_s.touching    <= !depth_w[ARM_W-1] && (depth_w != '0);
			out_s.depth       <= depth_w[31:0];
			out_s.p1          <= geo_w.p1;
			out_s.neg         <= geo_w.neg;
			out_s.mag         <= geo_w.mag;
			out_s.center_dist <= dist_w;
			out_s.arm         <= arm_w;
		end
	end

endmodule

// ----- rtl/spcg_queue.sv -----
// Short queue that decouples the front part from the back part.
module spcg_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  spcg_pkg::item_t       item_i,
	input  logic                  pop,
	output spcg_pkg::item_t       item_o,
	output spcg_pkg::queue_stat_t stat
);
	import spcg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign item_o     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= item_i;
	end

endmodule

// ----- rtl/spcg_back.sv -----
// Back part: normal division pipeline, contact offset, rounding and saturation.
module spcg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spcg_pkg::item_t       item,
	input  logic                  queue_empty,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [223:0]          m_tdata,
	output logic [0:0]            m_tuser
);
	import spcg_pkg::*;

	localparam int ALO_W = 17;
	localparam int AHI_W = ARM_W - ALO_W;
	localparam int PPH_W = AHI_W + QUO_W;
	localparam int PPL_W = ALO_W + QUO_W;
	localparam int RSH   = 31;
	localparam int RND_W = SUM_W - RSH;
	localparam int CON_W = 37;

	logic                    en;

	logic                    dv_s   [QUO_W+1];
	item_t                   dit_s  [QUO_W+1];
	logic [2:0][NUM_W-1:0]   rem_s  [QUO_W+1];
	logic [2:0][QUO_W-1:0]   quo_s  [QUO_W+1];
	logic [2:0][NUM_W-1:0]   rem_nx [QUO_W];
	logic [2:0][QUO_W-1:0]   quo_nx [QUO_W];
	logic [NUM_W-1:0]        dsh    [QUO_W];

	logic                    nrm_v_s;
	item_t                   nrm_it_s;
	logic [2:0][QUO_W-1:0]   nrm_q_s;
	logic [ARM_W-1:0]        nrm_am_s;
	logic [2:0]              nrm_sg_s;

	logic                    pp_v_s;
	item_t                   pp_it_s;
	logic [2:0][QUO_W-1:0]   pp_q_s;
	logic [2:0]              pp_sg_s;
	logic [2:0][PPH_W-1:0]   pp_hi_s;
	logic [2:0][PPL_W-1:0]   pp_lo_s;

	logic                    rnd_v_s;
	item_t                   rnd_it_s;
	logic [2:0][QUO_W-1:0]   rnd_q_s;
	logic [2:0]              rnd_sg_s;
	logic [2:0][RND_W-1:0]   rnd_m_s;

	logic                    res_v_s;
	logic                    res_touch_s;
	logic [2:0][31:0]        res_n_s;
	logic [31:0]             res_depth_s;
	logic [2:0][31:0]        res_c_s;

	logic [2:0][QUO_W-1:0]   qfix;
	logic [2:0][SUM_W-1:0]   mag_sum;
	logic [2:0][CON_W-1:0]   off_w, con_w;
	logic [2:0][31:0]        sat_w, nrm_w;

	assign en       = !res_v_s || m_tready;
	assign pop      = en && !queue_empty;
	assign m_tvalid = res_v_s;
	assign m_tuser  = res_touch_s;
	assign m_tdata  = {res_c_s[2], res_c_s[1], res_c_s[0], res_depth_s,
		res_n_s[2], res_n_s[1], res_n_s[0]};

	// One quotient bit per stage and lane.
	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			dsh[k] = NUM_W'(dit_s[k].center_dist) << (QUO_W - 1 - k);
			for (int i = 0; i < 3; i++) begin
				if (rem_s[k][i] >= dsh[k]) begin
					rem_nx[k][i] = rem_s[k][i] - dsh[k];
					quo_nx[k][i] = quo_s[k][i] | (QUO_W'(1) << (QUO_W - 1 - k));
				end else begin
					rem_nx[k][i] = rem_s[k][i];
					quo_nx[k][i] = quo_s[k][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dit_s[QUO_W].center_dist == '0)
				qfix[i] = '0;
			else if (quo_s[QUO_W][i] > ONE_Q30)
				qfix[i] = ONE_Q30;
			else
				qfix[i] = quo_s[QUO_W][i];
			mag_sum[i] = (SUM_W'(pp_hi_s[i]) << ALO_W) + SUM_W'(pp_lo_s[i]) +
				(SUM_W'(1) << (RSH - 1));
			off_w[i] = rnd_sg_s[i] ? (CON_W'(0) - CON_W'(rnd_m_s[i])) : CON_W'(rnd_m_s[i]);
			con_w[i] = CON_W'($signed(rnd_it_s.p1[i])) + off_w[i];
			if (con_w[i][CON_W-1] && (con_w[i][CON_W-2:31] != '1))
				sat_w[i] = 32'h8000_0000;
			else if (!con_w[i][CON_W-1] && (con_w[i][CON_W-2:31] != '0))
				sat_w[i] = 32'h7fff_ffff;
			else
				sat_w[i] = con_w[i][31:0];
			nrm_w[i] = rnd_it_s.neg[i] ? (32'd0 - 32'(rnd_q_s[i])) : 32'(rnd_q_s[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++) dv_s[k] <= 1'b0;
			nrm_v_s <= 1'b0;
			pp_v_s  <= 1'b0;
			rnd_v_s <= 1'b0;
			res_v_s <= 1'b0;
		end else if (en) begin
			dv_s[0] <= !queue_empty;
			for (int k = 0; k < QUO_W; k++) dv_s[k+1] <= dv_s[k];
			nrm_v_s <= dv_s[QUO_W];
			pp_v_s  <= nrm_v_s;
			rnd_v_s <= pp_v_s;
			res_v_s <= rnd_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dit_s[0] <= item;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= (NUM_W'(item.mag[i]) << (QUO_W - 1)) +
					NUM_W'(item.center_dist >> 1);
				quo_s[0][i] <= '0;
			end
			for (int k = 0; k < QUO_W; k++) begin
				dit_s[k+1] <= dit_s[k];
				rem_s[k+1] <= rem_nx[k];
				quo_s[k+1] <= quo_nx[k];
			end

			nrm_it_s <= dit_s[QUO_W];
			nrm_q_s  <= qfix;
			nrm_am_s <= dit_s[QUO_W].arm[ARM_W-1] ? (ARM_W'(0) - dit_s[QUO_W].arm) :
				dit_s[QUO_W].arm;
			for (int i = 0; i < 3; i++)
				nrm_sg_s[i] <= dit_s[QUO_W].arm[ARM_W-1] ^ dit_s[QUO_W].neg[i];

			pp_it_s <= nrm_it_s;
			pp_q_s  <= nrm_q_s;
			pp_sg_s <= nrm_sg_s;
			for (int i = 0; i < 3; i++) begin
				pp_hi_s[i] <= PPH_W'(nrm_am_s[ARM_W-1:ALO_W]) * PPH_W'(nrm_q_s[i]);
				pp_lo_s[i] <= PPL_W'(nrm_am_s[ALO_W-1:0]) * PPL_W'(nrm_q_s[i]);
			end

			rnd_it_s <= pp_it_s;
			rnd_q_s  <= pp_q_s;
			rnd_sg_s <= pp_sg_s;
			for (int i = 0; i < 3; i++)
				rnd_m_s[i] <= mag_sum[i][SUM_W-1:RSH];

			res_touch_s <= rnd_it_s.touching;
			res_depth_s <= rnd_it_s.touching ? rnd_it_s.depth : 32'd0;
			for (int i = 0; i < 3; i++) begin
				res_n_s[i] <= rnd_it_s.touching ? nrm_w[i] : 32'd0;
				res_c_s[i] <= rnd_it_s.touching ? sat_w[i] : 32'd0;
			end
		end
	end

endmodule

// ----- rtl/sphere_pair_contact_geometry_unit.sv -----
// Top level of the sphere pair contact geometry unit.
//
// Channel  Dir  Signals                     Contents
// s_       in   tvalid tready tdata[255:0]  one sphere pair
// m_       out  tvalid tready tdata[223:0]  contact result, tuser[0] = touching
//
// One pair is taken per clock when the result side keeps up. A pair passes
// from input to output through 38 front stages set by the 33-step root
// pipeline, the queue memory, and 36 back stages set by the 31-step divide.
// Reset clears the stage valid bits and the queue pointers; no payload is cleared.
// A stalled output stalls the back part; the front part keeps taking pairs until
// the queue is full, and only then does s_tready fall.
module sphere_pair_contact_geometry_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_center_x, first_center_y, first_center_z, second_center_x,
	// second_center_y, second_center_z, first_radius, second_radius, zero pad
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z, overlap_depth, contact_x, contact_y, contact_z
	output logic [223:0] m_tdata,
	// touching
	output logic [0:0]   m_tuser
);
	import spcg_pkg::*;

	logic        front_valid;
	item_t       front_item;
	item_t       queue_item;
	queue_stat_t q_stat;
	logic        push;
	logic        pop;

	// A finished front transaction enters the queue whenever there is room.
	assign push = front_valid && !q_stat.full;

	spcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (q_stat.full),
		.item_valid (front_valid),
		.item       (front_item)
	);

	spcg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item_i (front_item),
		.pop    (pop),
		.item_o (queue_item),
		.stat   (q_stat)
	);

	spcg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (queue_item),
		.queue_empty (q_stat.empty),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

`ifndef SYNTHESIS
	// Without contact every result field is zero.
	a_no_contact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("result fields not zero without contact");

	// A contact always carries a nonzero depth.
	a_contact_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[127:96] != 32'd0)
		else $error("contact with zero depth");

	// The normal x component stays within one in Q1.30.
	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824 &&
			$signed(m_tdata[31:0]) >= -32'sd1073741824))
		else $error("normal component out of range");

	// The input side stalls only because the queue is full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_stat.full && front_valid)
		else $error("input stalled while the queue has room");
`endif

endmodule
